[hdl/sprq_pkg.sv]
// Shared types and codes for the sorted process ready queue.
`timescale 1ns / 1ps

package sprq_pkg;

    localparam int TAG_W   = 8;
    localparam int TIME_W  = 16;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND      = 2'd0,
        OP_INS_ARRIVAL = 2'd1,
        OP_INS_BURST   = 2'd2,
        OP_DEQUEUE     = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
    } entry_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic by_arrival;
        logic by_burst;
        logic dequeue;
    } cell_ctrl_t;

endpackage

[hdl/sprq_req_if.sv]
// Request channel: one queue operation with the entry to insert.
`timescale 1ns / 1ps

interface sprq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  proc_tag;
    logic [15:0] arrival_time;
    logic [15:0] burst_remaining;

    modport source (output valid, output operation, output proc_tag,
                    output arrival_time, output burst_remaining, input ready);
    modport sink   (input valid, input operation, input proc_tag,
                    input arrival_time, input burst_remaining, output ready);
endinterface

[hdl/sprq_rsp_if.sv]
// Response channel: status, dequeued entry and occupancy.
`timescale 1ns / 1ps

interface sprq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  out_tag;
    logic [15:0] out_arrival;
    logic [15:0] out_burst;
    logic [4:0]  occupancy;

    modport source (output valid, output status, output out_tag, output out_arrival,
                    output out_burst, output occupancy, input ready);
    modport sink   (input valid, input status, input out_tag, input out_arrival,
                    input out_burst, input occupancy, output ready);
endinterface

[hdl/sorted_process_ready_queue_core.sv]
// Top level of the sorted process ready queue: cell chain, count and response register.
`timescale 1ns / 1ps

// Bounded ready queue of process entries (tag, arrival time, remaining burst).
// Requests arrive on req; each carries an operation: append at tail, insert
// ordered by arrival, insert ordered by burst (both stable), or dequeue head.
// Every request yields exactly one response on rsp with a status (done,
// empty on dequeue, full on dropped insert), the dequeued entry (zero
// otherwise) and the occupancy after the operation.
// The response is registered and becomes valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the response side is not stalled;
// every cell compares its key with the new entry in parallel and the insert
// point ripples down the chain, so the whole chain updates together.
// Reset clears the entry count and the response valid flag; slot contents are
// not cleared and are only read below the count.
// When rsp stalls, the finished response holds and req.ready drops until
// the response is taken; a new request is accepted in the same cycle the
// pending response leaves.
module sorted_process_ready_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic      clk,
    input logic      rst_n,
    sprq_req_if.sink   req,
    sprq_rsp_if.source rsp
);
    import sprq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           rsp_valid_reg;
    status_t        status_reg;
    status_t        status_next;
    entry_t         head_reg;
    entry_t         head_next;

    logic           accept;
    logic           is_full;
    logic           is_empty;
    op_t            op;
    entry_t         new_entry;
    cell_ctrl_t     ctrl;

    logic   [QUEUE_DEPTH-1:0] valid;
    logic   [QUEUE_DEPTH:0]   found;
    entry_t                   cell_entry [QUEUE_DEPTH];

    logic [CW+OCC_W-1:0] occ_ext;

    // Hold off new requests while a response waits to be taken.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign op        = op_t'(req.operation);
    assign new_entry = '{tag: req.proc_tag, arrival: req.arrival_time,
                         burst: req.burst_remaining};

    assign is_full  = (count_reg == CW'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    // Broadcast command; a blocked operation leaves every cell untouched.
    always_comb
    begin
        ctrl.insert     = accept && (op != OP_DEQUEUE) && !is_full;
        ctrl.by_arrival = (op == OP_INS_ARRIVAL);
        ctrl.by_burst   = (op == OP_INS_BURST);
        ctrl.dequeue    = accept && (op == OP_DEQUEUE) && !is_empty;
    end

    assign found[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t prev_e;
            entry_t next_e;

            // Occupied slots are contiguous from the head.
            assign valid[gi] = (count_reg > CW'(gi));

            if (gi == 0)
            begin : g_head
                assign prev_e = new_entry;
            end
            else
            begin : g_body
                assign prev_e = cell_entry[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign next_e = '0;
            end
            else
            begin : g_mid
                assign next_e = cell_entry[gi+1];
            end

            sprq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .valid      (valid[gi]),
                .found_in   (found[gi]),
                .new_entry  (new_entry),
                .prev_entry (prev_e),
                .next_entry (next_e),
                .found_out  (found[gi+1]),
                .entry      (cell_entry[gi])
            );
        end
    endgenerate

    // Status, head capture and count update for the accepted request.
    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_DONE;
        head_next   = '0;
        if (op == OP_DEQUEUE)
        begin
            if (is_empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                head_next  = cell_entry[0];
                count_next = count_reg - CW'(1);
            end
        end
        else if (is_full)
        begin
            status_next = ST_FULL;
        end
        else
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload needs no reset; it is qualified by rsp.valid.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            head_reg   <= head_next;
        end
    end

    // Report the low bits of the count, zero-extended for shallow queues.
    assign occ_ext = {{OCC_W{1'b0}}, count_reg};

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.out_tag     = head_reg.tag;
    assign rsp.out_arrival = head_reg.arrival;
    assign rsp.out_burst   = head_reg.burst;
    assign rsp.occupancy   = occ_ext[OCC_W-1:0];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |-> !accept)
        else $error("request accepted while response stalled");

    a_dequeue_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.dequeue |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("dequeue did not decrement count");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg == ST_FULL)) |-> (count_reg == CW'(QUEUE_DEPTH)))
        else $error("full status reported with free slots");
`endif

endmodule

[hdl/sprq_cell.sv]
// One slot of the queue chain: holds an entry, shifts toward tail or head.
`timescale 1ns / 1ps

module sprq_cell (
    input  logic                clk,
    input  sprq_pkg::cell_ctrl_t ctrl,
    input  logic                valid,
    input  logic                found_in,
    input  sprq_pkg::entry_t    new_entry,
    input  sprq_pkg::entry_t    prev_entry,
    input  sprq_pkg::entry_t    next_entry,
    output logic                found_out,
    output sprq_pkg::entry_t    entry
);
    import sprq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   hit;

    // Insert point: first empty slot, or first held key strictly greater.
    assign hit = !valid
               || (ctrl.by_arrival && (new_entry.arrival < entry_reg.arrival))
               || (ctrl.by_burst && (new_entry.burst < entry_reg.burst));

    assign found_out = found_in | hit;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert)
        begin
            if (found_in)
                entry_next = prev_entry;
            else if (hit)
                entry_next = new_entry;
        end
        else if (ctrl.dequeue)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[verif/sorted_process_ready_queue_core_test.sv]
// Self-checking testbench for the sorted process ready queue core.
`timescale 1ns / 1ps

module sorted_process_ready_queue_core_test;

    import sprq_pkg::*;

    localparam int QUEUE_DEPTH   = 16;
    localparam int RANDOM_ITEMS  = 450;
    localparam int DIRECTED_ROWS = 23;
    // Cycles the receiver refuses responses during the back-pressure stretch.
    localparam int LONG_HOLD     = 150;
    // Extra cycles to wait after the last response before the verdict.
    localparam int DRAIN_CYCLES  = 6;

    // One response as the block reports it.
    typedef struct packed {
        status_t           status;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [OCC_W-1:0]  occupancy;
    } queue_rsp_t;

    // One request, plus a typed-in outcome where it is obvious. Rows with
    // has_fixed set expect zero entry fields, so only status and occupancy
    // are given.
    typedef struct packed {
        op_t               op;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic              has_fixed;
        status_t           fixed_status;
        logic [OCC_W-1:0]  fixed_occ;
    } stim_row_t;

    logic clk;
    logic rst_n;

    sprq_req_if req_ch ();
    sprq_rsp_if rsp_ch ();

    sorted_process_ready_queue_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Shadow copy of the queue contents, head at index 0.
    entry_t     shadow_slots [QUEUE_DEPTH];
    int         shadow_count;

    // Responses predicted for accepted requests, oldest first.
    queue_rsp_t due_responses [$];

    int  error_count;
    int  op_seen [4];
    int  full_drops;
    int  empty_dequeues;
    int  peak_occupancy;
    int  responses_checked;
    bit  long_hold_req;

    // Directed table: empty dequeue after reset, extreme keys, ties on both
    // sort keys, filling to capacity and every insert kind against a full
    // queue.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_DEQUEUE,     8'h00, 16'h0000, 16'h0000, 1'b1, ST_EMPTY, 5'd0},
        '{OP_APPEND,      8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, ST_DONE,  5'd1},
        '{OP_INS_ARRIVAL, 8'h00, 16'h0000, 16'h0000, 1'b1, ST_DONE,  5'd2},
        '{OP_INS_BURST,   8'h5A, 16'h1234, 16'h8000, 1'b0, ST_DONE,  5'd0},
        '{OP_INS_ARRIVAL, 8'h11, 16'hFFFF, 16'h0001, 1'b0, ST_DONE,  5'd0},
        '{OP_INS_BURST,   8'h22, 16'h7FFF, 16'h0000, 1'b0, ST_DONE,  5'd0},
        '{OP_DEQUEUE,     8'hC3, 16'hA5A5, 16'h5A5A, 1'b0, ST_DONE,  5'd0},
        '{OP_APPEND,      8'h30, 16'h0001, 16'hFFFE, 1'b0, ST_DONE,  5'd0},
        '{OP_APPEND,      8'h31, 16'h0002, 16'hFFFD, 1'b0, ST_DONE,  5'd0},
        '{OP_APPEND,      8'h32, 16'h0004, 16'hFFFB, 1'b0, ST_DONE,  5'd0},
        '{OP_APPEND,      8'h33, 16'h0008, 16'hFFF7, 1'b0, ST_DONE,  5'd0},
        '{OP_APPEND,      8'h34, 16'h0010, 16'hFFEF, 1'b0, ST_DONE,  5'd0},
        '{OP_APPEND,      8'h35, 16'h0020, 16'hFFDF, 1'b0, ST_DONE,  5'd0},
        '{OP_APPEND,      8'h36, 16'h0040, 16'hFFBF, 1'b0, ST_DONE,  5'd0},
        '{OP_APPEND,      8'h37, 16'h0080, 16'hFF7F, 1'b0, ST_DONE,  5'd0},
        '{OP_APPEND,      8'h38, 16'h0100, 16'hFEFF, 1'b0, ST_DONE,  5'd0},
        '{OP_APPEND,      8'h39, 16'h0200, 16'hFDFF, 1'b0, ST_DONE,  5'd0},
        '{OP_APPEND,      8'h3A, 16'h0400, 16'hFBFF, 1'b0, ST_DONE,  5'd0},
        '{OP_APPEND,      8'h3B, 16'h8000, 16'h7FFF, 1'b0, ST_DONE,  5'd0},
        '{OP_INS_BURST,   8'h99, 16'h0000, 16'h0000, 1'b1, ST_FULL,  5'd16},
        '{OP_APPEND,      8'hA5, 16'hAAAA, 16'h5555, 1'b1, ST_FULL,  5'd16},
        '{OP_INS_ARRIVAL, 8'h5A, 16'h5555, 16'hAAAA, 1'b1, ST_FULL,  5'd16},
        '{OP_DEQUEUE,     8'h00, 16'h0000, 16'h0000, 1'b0, ST_DONE,  5'd0}
    };

    // Apply one operation to the shadow queue and return the response it
    // should produce.
    function automatic queue_rsp_t next_queue_response(input op_t op, input entry_t ent);
        queue_rsp_t rsp;
        int         pos;
        int         i;
        bit         found;
        rsp = '0;
        rsp.status = ST_DONE;
        found = 1'b0;
        if (op == OP_DEQUEUE)
        begin
            if (shadow_count == 0)
            begin
                rsp.status = ST_EMPTY;
            end
            else
            begin
                rsp.tag     = shadow_slots[0].tag;
                rsp.arrival = shadow_slots[0].arrival;
                rsp.burst   = shadow_slots[0].burst;
                for (i = 1; i < shadow_count; i++)
                    shadow_slots[i-1] = shadow_slots[i];
                shadow_count--;
            end
        end
        else if (shadow_count >= QUEUE_DEPTH)
        begin
            rsp.status = ST_FULL;
        end
        else
        begin
            // Stable insert: go before the first entry with a strictly greater key.
            pos = shadow_count;
            for (i = 0; i < shadow_count; i++)
            begin
                if (!found && op == OP_INS_ARRIVAL && ent.arrival < shadow_slots[i].arrival)
                begin
                    pos = i;
                    found = 1'b1;
                end
                if (!found && op == OP_INS_BURST && ent.burst < shadow_slots[i].burst)
                begin
                    pos = i;
                    found = 1'b1;
                end
            end
            for (i = shadow_count; i > pos; i--)
                shadow_slots[i] = shadow_slots[i-1];
            shadow_slots[pos] = ent;
            shadow_count++;
        end
        rsp.occupancy = shadow_count[OCC_W-1:0];
        return rsp;
    endfunction

    // Clock: 20 ns period.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offer one request from the falling edge on and hold it until accepted.
    // On acceptance, advance the shadow queue and queue the expected response.
    task automatic send_request(input stim_row_t row);
        entry_t     ent;
        queue_rsp_t predicted;
        @(negedge clk);
        req_ch.valid           <= 1'b1;
        req_ch.operation       <= row.op;
        req_ch.proc_tag        <= row.tag;
        req_ch.arrival_time    <= row.arrival;
        req_ch.burst_remaining <= row.burst;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        ent.tag     = row.tag;
        ent.arrival = row.arrival;
        ent.burst   = row.burst;
        predicted = next_queue_response(row.op, ent);
        if (row.has_fixed)
        begin
            predicted        = '0;
            predicted.status = row.fixed_status;
            predicted.occupancy = row.fixed_occ;
        end
        due_responses.push_back(predicted);
        op_seen[row.op]++;
        if (predicted.status == ST_FULL)
            full_drops++;
        if (predicted.status == ST_EMPTY)
            empty_dequeues++;
        if (shadow_count > peak_occupancy)
            peak_occupancy = shadow_count;
    endtask

    // Drop valid for a number of cycles; the payload keeps its last value.
    task automatic idle_request(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
    endtask

    // Receiver: ready follows a mode that rotates with the tick count (always
    // ready, coin toss, fixed stall pattern). On request, hold off for a
    // long stretch so that the response register fills and the block stalls
    // its input.
    initial
    begin
        int unsigned tick;
        int          hold_left;
        logic [7:0]  stall_pattern;
        tick = 0;
        hold_left = 0;
        stall_pattern = 8'b1011_0010;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_left == 0 && long_hold_req)
            begin
                hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case ((tick / 64) % 3)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(1) == 1);
                    default: rsp_ch.ready <= stall_pattern[tick % 8];
                endcase
            end
        end
    end

    // Response checker: compare every accepted response with the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        queue_rsp_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (due_responses.size() == 0)
            begin
                $display("%0t: response with none expected (status %0d, occupancy %0d)",
                         $time, rsp_ch.status, rsp_ch.occupancy);
                error_count++;
            end
            else
            begin
                want = due_responses.pop_front();
                responses_checked++;
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.out_tag !== want.tag)
                begin
                    $display("%0t: out_tag mismatch, expected %h, actual %h",
                             $time, want.tag, rsp_ch.out_tag);
                    error_count++;
                end
                if (rsp_ch.out_arrival !== want.arrival)
                begin
                    $display("%0t: out_arrival mismatch, expected %h, actual %h",
                             $time, want.arrival, rsp_ch.out_arrival);
                    error_count++;
                end
                if (rsp_ch.out_burst !== want.burst)
                begin
                    $display("%0t: out_burst mismatch, expected %h, actual %h",
                             $time, want.burst, rsp_ch.out_burst);
                    error_count++;
                end
                if (rsp_ch.occupancy !== want.occupancy)
                begin
                    $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                             $time, want.occupancy, rsp_ch.occupancy);
                    error_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, then random requests.
    initial
    begin
        stim_row_t row;
        int        n;
        int        run_left;
        int        dequeue_pct;
        int        key_mode;
        error_count       = 0;
        full_drops        = 0;
        empty_dequeues    = 0;
        peak_occupancy    = 0;
        responses_checked = 0;
        shadow_count      = 0;
        long_hold_req     = 1'b0;
        op_seen           = '{0, 0, 0, 0};
        run_left          = 0;
        dequeue_pct       = 30;

        rst_n                  = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.operation       = OP_APPEND;
        req_ch.proc_tag        = '0;
        req_ch.arrival_time    = '0;
        req_ch.burst_remaining = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table with short random gaps.
        for (n = 0; n < DIRECTED_ROWS; n++)
        begin
            send_request(directed_rows[n]);
            if ($urandom_range(2) == 0)
                idle_request($urandom_range(1, 3));
        end

        // Random part. Every 50 requests pick a new dequeue share so that the
        // queue swings between empty and full. Half the keys come from a narrow
        // range and a sixth are extremes, so that sorted inserts meet ties.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
            begin
                case ($urandom_range(3))
                    0:       dequeue_pct = 10;
                    1:       dequeue_pct = 35;
                    2:       dequeue_pct = 55;
                    default: dequeue_pct = 85;
                endcase
            end
            row = '0;
            if ($urandom_range(99) < dequeue_pct)
                row.op = OP_DEQUEUE;
            else
                row.op = op_t'($urandom_range(2));
            row.tag = TAG_W'($urandom_range(255));
            key_mode = $urandom_range(5);
            case (key_mode)
                0, 1:
                begin
                    row.arrival = TIME_W'($urandom_range(65535));
                    row.burst   = TIME_W'($urandom_range(65535));
                end
                2:
                begin
                    row.arrival = ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000;
                    row.burst   = ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000;
                end
                default:
                begin
                    row.arrival = TIME_W'($urandom_range(7));
                    row.burst   = TIME_W'($urandom_range(7));
                end
            endcase

            // Back-pressure: starve the response side while requests keep coming.
            if (n == 150)
                long_hold_req = 1'b1;

            // Hold the sender until every outstanding response has arrived.
            if (n == 300)
            begin
                idle_request(1);
                while (due_responses.size() != 0)
                    @(negedge clk);
            end

            // Bursts of random length with random gaps; zero gaps give
            // back-to-back stretches.
            if (run_left == 0)
            begin
                idle_request($urandom_range(0, 6));
                run_left = $urandom_range(1, 12);
            end
            run_left--;
            send_request(row);
        end

        idle_request(1);
        while (due_responses.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests (%0d append, %0d by arrival, %0d by burst, %0d dequeue);",
                 op_seen[OP_APPEND] + op_seen[OP_INS_ARRIVAL] + op_seen[OP_INS_BURST]
                 + op_seen[OP_DEQUEUE], op_seen[OP_APPEND], op_seen[OP_INS_ARRIVAL],
                 op_seen[OP_INS_BURST], op_seen[OP_DEQUEUE]);
        $display("%0d responses checked, %0d dropped inserts, %0d empty dequeues, peak %0d",
                 responses_checked, full_drops, empty_dequeues, peak_occupancy);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: a correct run ends far sooner than this.
    initial
    begin
        #5_000_000;
        $display("%0t: timeout with %0d responses outstanding", $time, due_responses.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
